// ----- design/gsng_pkg.sv -----
// ----------------------------------------------------------------------------
// gsng_pkg
// shared types and constants of the grid surface normal generator
// ----------------------------------------------------------------------------
package gsng_pkg;

  localparam int SIDE_W   = 6;
  localparam int NQ_W     = 16;
  localparam int ONE_Q14  = 16384;
  localparam int TINY_MAG = 53687;
  localparam logic [61:0] TINY_SQ = 62'd2882303761;

  typedef struct packed {
    logic start;
    logic tiny;
  } norm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } norm_rsp_t;

endpackage

// ----- design/gsng_ram.sv -----
// ----------------------------------------------------------------------------
// gsng_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gsng_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 126
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/gsng_norm.sv -----
// ----------------------------------------------------------------------------
// gsng_norm
// shared vector normalize unit: scale, sum of squares, bitwise square root,
// restoring divide to q1.14, with the near-zero bypass for the averaged normal
// ----------------------------------------------------------------------------
module gsng_norm #(
  parameter int VW = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gsng_pkg::norm_req_t                   req_i,
  input  logic signed [VW-1:0]                  vec_i [3],
  output gsng_pkg::norm_rsp_t                   rsp_o,
  output logic signed [gsng_pkg::NQ_W-1:0]      res_o [3]
);
  import gsng_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE, N_CHECK, N_SCALE, N_SQ, N_ROOT, N_DINIT, N_DIV
  } state_e;

  state_e            state_q;
  logic [VW-1:0]     m_q [3];
  logic [2:0]        neg_q;
  logic              tiny_q;
  logic              raw_q;
  logic [1:0]        cnt_q;
  logic [61:0]       acc_q;
  logic [61:0]       n_q;
  logic [61:0]       r_q;
  logic [60:0]       b_q;
  logic [45:0]       rem_q [3];
  logic [45:0]       dv_q;
  logic [14:0]       quo_q [3];
  logic [3:0]        dcnt_q;
  logic              done_q;
  logic signed [NQ_W-1:0] res_q [3];

  logic [VW-1:0]     mx;
  logic [29:0]       sq_op;
  logic [59:0]       prod;
  logic [61:0]       acc_d;
  logic [61:0]       rt;
  logic              root_ge;
  logic [2:0]        div_ge;
  logic [14:0]       quo_d [3];
  logic              done_d;

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
  end

  always_comb begin
    case (cnt_q)
      2'd0:    sq_op = m_q[0][29:0];
      2'd1:    sq_op = m_q[1][29:0];
      default: sq_op = m_q[2][29:0];
    endcase
  end

  assign prod    = sq_op * sq_op;
  assign acc_d   = acc_q + 62'(prod);
  assign rt      = r_q + 62'(b_q);
  assign root_ge = (n_q >= rt);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_ge[i] = (rem_q[i] >= dv_q);
      quo_d[i]  = {quo_q[i][13:0], div_ge[i]};
    end
  end

  // result is ready: zero vector, near-zero bypass, or last divide step
  assign done_d = ((state_q == N_CHECK) && (mx == '0)) ||
                  ((state_q == N_SQ) && (cnt_q == 2'd2) && raw_q &&
                   (acc_d <= TINY_SQ)) ||
                  ((state_q == N_DIV) && (dcnt_q == 4'd14));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      raw_q   <= 1'b0;
      tiny_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      case (state_q)
        N_IDLE: begin
          if (req_i.start) begin
            for (int i = 0; i < 3; i++) begin
              m_q[i]   <= vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
              neg_q[i] <= vec_i[i][VW-1];
            end
            tiny_q  <= req_i.tiny;
            raw_q   <= 1'b0;
            state_q <= N_CHECK;
          end
        end
        N_CHECK: begin
          cnt_q <= '0;
          acc_q <= '0;
          if (mx == '0) begin
            for (int i = 0; i < 3; i++) res_q[i] <= '0;
            state_q <= N_IDLE;
          end else if (tiny_q && (mx <= VW'(TINY_MAG))) begin
            // exact length check on the raw vector first
            raw_q   <= 1'b1;
            state_q <= N_SQ;
          end else begin
            state_q <= N_SCALE;
          end
        end
        N_SCALE: begin
          // coarse steps of eight, fine steps of one, right shifts truncate
          if ((mx >> 38) != '0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 8;
          end else if ((mx >> 30) != '0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
          end else if ((mx >> 21) == '0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 8;
          end else if ((mx >> 29) == '0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
          end else begin
            raw_q   <= 1'b0;
            cnt_q   <= '0;
            acc_q   <= '0;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          acc_q <= acc_d;
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd2) begin
            if (raw_q) begin
              if (acc_d <= TINY_SQ) begin
                for (int i = 0; i < 3; i++) begin
                  logic [16:0] tq;
                  logic signed [NQ_W-1:0] ts;
                  tq = (17'(m_q[i][16:0]) + 17'(ONE_Q14)) >> 15;
                  ts = signed'(NQ_W'(tq));
                  res_q[i] <= neg_q[i] ? -ts : ts;
                end
                state_q <= N_IDLE;
              end else begin
                raw_q   <= 1'b0;
                state_q <= N_SCALE;
              end
            end else begin
              n_q     <= acc_d;
              r_q     <= '0;
              b_q     <= 61'(1) << 60;
              state_q <= N_ROOT;
            end
          end
        end
        N_ROOT: begin
          // one result bit per cycle
          if (root_ge) begin
            n_q <= n_q - rt;
            r_q <= (r_q >> 1) + 62'(b_q);
          end else begin
            r_q <= r_q >> 1;
          end
          b_q <= b_q >> 2;
          if (b_q == 61'd1) state_q <= N_DINIT;
        end
        N_DINIT: begin
          for (int i = 0; i < 3; i++) begin
            rem_q[i] <= (46'(m_q[i][29:0]) << 14) + 46'(r_q[31:1]);
            quo_q[i] <= '0;
          end
          dv_q    <= 46'(r_q[31:0]) << 14;
          dcnt_q  <= '0;
          state_q <= N_DIV;
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (div_ge[i]) rem_q[i] <= rem_q[i] - dv_q;
            quo_q[i] <= quo_d[i];
          end
          dv_q   <= dv_q >> 1;
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'd14) begin
            for (int i = 0; i < 3; i++) begin
              logic signed [NQ_W-1:0] qs;
              qs = signed'(NQ_W'(quo_d[i]));
              res_q[i] <= neg_q[i] ? -qs : qs;
            end
            state_q <= N_IDLE;
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign rsp_o.busy = (state_q != N_IDLE);
  assign rsp_o.done = done_q;
  assign res_o      = res_q;

endmodule

// ----- design/grid_surface_normal_generator_core.sv -----
// ----------------------------------------------------------------------------
// grid_surface_normal_generator_core
// heightfield vertex normals from a line store of recent grid vertices
// ----------------------------------------------------------------------------
// Vertices of a square grid arrive row by row on the input channel
// (valid/ready, one word per vertex, signed q15.8). Each accepted vertex is
// written to a ring line store of 2*MAX_SIDE+2 entries. Normal e leaves on the
// output channel (q1.14, last_normal on the final grid vertex) once vertex
// e+side+1 has arrived; the final vertex flushes the side+1 normals still owed
// and the counters restart for the next grid.
// After accepting a vertex the block works on the normals it releases and
// accepts nothing else. An interior normal takes five reads of the line
// store, each difference and the averaged cross product going through the
// one shared normalize unit (its 31-step square root and 15-step divide),
// and a cross product formed one component at a time.
// A finished normal sits in the output register; the next one waits in the
// block until that register is taken, so a stalled receiver holds the work.
// Reset sets grid_side to 32 and clears all counters; the line store needs no
// clearing, only vertices of the current grid are read. Writing grid_side
// restarts the grid.
// ----------------------------------------------------------------------------
module grid_surface_normal_generator_core #(
  parameter int MAX_SIDE   = 62,
  parameter int COORD_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gsng_pkg::SIDE_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COORD_BITS-1:0]       pos_x_i,
  input  logic signed [COORD_BITS-1:0]       pos_y_i,
  input  logic signed [COORD_BITS-1:0]       pos_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [gsng_pkg::NQ_W-1:0]   normal_x_o,
  output logic signed [gsng_pkg::NQ_W-1:0]   normal_y_o,
  output logic signed [gsng_pkg::NQ_W-1:0]   normal_z_o,
  output logic                               last_normal_o
);
  import gsng_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int VW    = (DW > 32) ? DW : 32;
  localparam int DEPTH = 2 * MAX_SIDE + 2;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    T_IDLE, T_CHECK, T_RDP, T_LDP, T_RDN, T_DIFF, T_NWAIT,
    T_CROSS, T_SNORM, T_SWAIT, T_OUT
  } state_e;

  state_e                  state_q;
  logic [SIDE_W-1:0]       side_q;
  logic [SIDE_W-1:0]       col_q, row_q;
  logic [SIDE_W-1:0]       ecol_q, erow_q;
  logic [AW-1:0]           wr_ptr_q, e_ptr_q;
  logic [6:0]              gap_q;
  logic                    last_q;
  logic [1:0]              nb_q;
  logic [1:0]              cc_q;
  logic signed [CW-1:0]    p_q [3];
  logic signed [NQ_W-1:0]  uv_q [4][3];
  logic signed [31:0]      s_q [3];
  logic signed [NQ_W-1:0]  nrm_q [3];
  logic                    out_valid_q;
  logic signed [NQ_W-1:0]  out_x_q, out_y_q, out_z_q;
  logic                    out_last_q;

  logic [SIDE_W-1:0]       side_eff;
  logic                    in_acc;
  logic                    in_final;
  logic                    e_final;
  logic                    e_border;
  logic                    pending;
  logic                    out_load;
  logic [AW-1:0]           nb_addr;
  logic [AW-1:0]           rd_addr;
  logic                    rd_en;
  logic [3*CW-1:0]         rdata;
  logic signed [CW-1:0]    rd_c [3];
  logic signed [VW-1:0]    norm_vec [3];
  logic signed [NQ_W-1:0]  norm_res [3];
  norm_req_t               norm_req;
  norm_rsp_t               norm_rsp;
  logic signed [NQ_W-1:0]  uj, uk, rj, rk, dj, dk, lj, lk;
  logic signed [31:0]      pr0, pr1, pr2, pr3;

  always_comb begin
    if (side_q == '0) begin
      side_eff = SIDE_W'(1);
    end else if (side_q > SIDE_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = side_q;
    end
  end

  assign in_ready_o = (state_q == T_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_final   = (col_q == side_eff - 1'b1) && (row_q == side_eff - 1'b1);
  assign e_final    = (ecol_q == side_eff - 1'b1) && (erow_q == side_eff - 1'b1);
  assign e_border   = (ecol_q == '0) || (erow_q == '0) ||
                      (ecol_q >= side_eff - 1'b1) || (erow_q >= side_eff - 1'b1);
  assign pending    = (gap_q != '0) && ((gap_q >= 7'(side_eff) + 7'd2) || last_q);
  assign out_load   = (state_q == T_OUT) && (!out_valid_q || out_ready_i);

  // neighbour address in the ring: up, right, down, left
  always_comb begin
    logic [AW:0] t;
    t = '0;
    case (nb_q)
      2'd0: begin
        t = {1'b0, e_ptr_q} + (AW+1)'(side_eff);
        if (t >= (AW+1)'(DEPTH)) t = t - (AW+1)'(DEPTH);
      end
      2'd1: begin
        t = (e_ptr_q == AW'(DEPTH - 1)) ? '0 : {1'b0, e_ptr_q} + 1'b1;
      end
      2'd2: begin
        if ({1'b0, e_ptr_q} >= (AW+1)'(side_eff)) begin
          t = {1'b0, e_ptr_q} - (AW+1)'(side_eff);
        end else begin
          t = {1'b0, e_ptr_q} + (AW+1)'(DEPTH) - (AW+1)'(side_eff);
        end
      end
      default: begin
        t = (e_ptr_q == '0) ? (AW+1)'(DEPTH - 1) : {1'b0, e_ptr_q} - 1'b1;
      end
    endcase
    nb_addr = t[AW-1:0];
  end

  assign rd_en   = (state_q == T_RDP) || (state_q == T_RDN);
  assign rd_addr = (state_q == T_RDP) ? e_ptr_q : nb_addr;

  gsng_ram #(
    .WIDTH (3 * CW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wr_ptr_q),
    .wdata_i ({pos_z_i, pos_y_i, pos_x_i}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign rd_c[0] = signed'(rdata[CW-1:0]);
  assign rd_c[1] = signed'(rdata[2*CW-1:CW]);
  assign rd_c[2] = signed'(rdata[3*CW-1:2*CW]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (state_q == T_SNORM) begin
        norm_vec[i] = VW'(s_q[i]);
      end else begin
        norm_vec[i] = VW'(p_q[i]) - VW'(rd_c[i]);
      end
    end
  end

  assign norm_req.start = (state_q == T_DIFF) || (state_q == T_SNORM);
  assign norm_req.tiny  = (state_q == T_SNORM);

  gsng_norm #(
    .VW (VW)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req),
    .vec_i  (norm_vec),
    .rsp_o  (norm_rsp),
    .res_o  (norm_res)
  );

  // one component of up x right + down x left per cycle
  always_comb begin
    case (cc_q)
      2'd0: begin
        uj = uv_q[0][1]; uk = uv_q[0][2]; rj = uv_q[1][1]; rk = uv_q[1][2];
        dj = uv_q[2][1]; dk = uv_q[2][2]; lj = uv_q[3][1]; lk = uv_q[3][2];
      end
      2'd1: begin
        uj = uv_q[0][2]; uk = uv_q[0][0]; rj = uv_q[1][2]; rk = uv_q[1][0];
        dj = uv_q[2][2]; dk = uv_q[2][0]; lj = uv_q[3][2]; lk = uv_q[3][0];
      end
      default: begin
        uj = uv_q[0][0]; uk = uv_q[0][1]; rj = uv_q[1][0]; rk = uv_q[1][1];
        dj = uv_q[2][0]; dk = uv_q[2][1]; lj = uv_q[3][0]; lk = uv_q[3][1];
      end
    endcase
  end

  assign pr0 = uj * rk;
  assign pr1 = uk * rj;
  assign pr2 = dj * lk;
  assign pr3 = dk * lj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      side_q      <= SIDE_W'(32);
      col_q       <= '0;
      row_q       <= '0;
      ecol_q      <= '0;
      erow_q      <= '0;
      wr_ptr_q    <= '0;
      e_ptr_q     <= '0;
      gap_q       <= '0;
      last_q      <= 1'b0;
      nb_q        <= '0;
      cc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) out_valid_q <= 1'b0;

      if (cfg_we_i) begin
        // new side restarts the grid
        side_q   <= cfg_wdata_i;
        col_q    <= '0;
        row_q    <= '0;
        ecol_q   <= '0;
        erow_q   <= '0;
        wr_ptr_q <= '0;
        e_ptr_q  <= '0;
        gap_q    <= '0;
        last_q   <= 1'b0;
      end else begin
        case (state_q)
          T_IDLE: begin
            if (in_acc) begin
              last_q <= in_final;
              gap_q  <= gap_q + 7'd1;
              if (in_final) begin
                col_q    <= '0;
                row_q    <= '0;
                wr_ptr_q <= '0;
              end else begin
                wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
                if (col_q == side_eff - 1'b1) begin
                  col_q <= '0;
                  row_q <= row_q + 1'b1;
                end else begin
                  col_q <= col_q + 1'b1;
                end
              end
              state_q <= T_CHECK;
            end
          end
          T_CHECK: begin
            if (!pending) begin
              last_q  <= 1'b0;
              state_q <= T_IDLE;
            end else if (e_border) begin
              nrm_q[0] <= '0;
              nrm_q[1] <= '0;
              nrm_q[2] <= NQ_W'(ONE_Q14);
              state_q  <= T_OUT;
            end else begin
              state_q <= T_RDP;
            end
          end
          T_RDP: state_q <= T_LDP;
          T_LDP: begin
            p_q     <= rd_c;
            nb_q    <= '0;
            state_q <= T_RDN;
          end
          T_RDN:  state_q <= T_DIFF;
          T_DIFF: state_q <= T_NWAIT;
          T_NWAIT: begin
            if (norm_rsp.done) begin
              uv_q[nb_q] <= norm_res;
              if (nb_q == 2'd3) begin
                cc_q    <= '0;
                state_q <= T_CROSS;
              end else begin
                nb_q    <= nb_q + 2'd1;
                state_q <= T_RDN;
              end
            end
          end
          T_CROSS: begin
            s_q[cc_q] <= pr0 - pr1 + pr2 - pr3;
            cc_q      <= cc_q + 2'd1;
            if (cc_q == 2'd2) state_q <= T_SNORM;
          end
          T_SNORM: state_q <= T_SWAIT;
          T_SWAIT: begin
            if (norm_rsp.done) begin
              for (int i = 0; i < 3; i++) nrm_q[i] <= -norm_res[i];
              state_q <= T_OUT;
            end
          end
          T_OUT: begin
            if (out_load) begin
              out_valid_q <= 1'b1;
              out_x_q     <= nrm_q[0];
              out_y_q     <= nrm_q[1];
              out_z_q     <= nrm_q[2];
              out_last_q  <= last_q && e_final;
              gap_q       <= gap_q - 7'd1;
              if (e_final) begin
                ecol_q  <= '0;
                erow_q  <= '0;
                e_ptr_q <= '0;
              end else begin
                e_ptr_q <= (e_ptr_q == AW'(DEPTH - 1)) ? '0 : e_ptr_q + 1'b1;
                if (ecol_q == side_eff - 1'b1) begin
                  ecol_q <= '0;
                  erow_q <= erow_q + 1'b1;
                end else begin
                  ecol_q <= ecol_q + 1'b1;
                end
              end
              state_q <= T_CHECK;
            end
          end
          default: state_q <= T_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign normal_x_o    = out_x_q;
  assign normal_y_o    = out_y_q;
  assign normal_z_o    = out_z_q;
  assign last_normal_o = out_last_q;

  a_gap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_IDLE) |-> (gap_q <= 7'(side_eff) + 7'd1))
    else $error("owed normals exceed the line store window while idle");

  a_norm_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_req.start |-> !norm_rsp.busy)
    else $error("normalize unit started while busy");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < side_eff) && (ecol_q < side_eff))
    else $error("column counter beyond grid side");

  a_grid_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && e_final && last_q) |=> (gap_q == '0 && e_ptr_q == '0))
    else $error("final normal did not restart the grid");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid surface normal generator testbench
// streams square grids of vertices with random gaps and output stalls, models
// the line store and fixed-point normal math, and checks every normal in order
// ----------------------------------------------------------------------------

typedef longint vec3_t [3];

typedef struct packed {
  logic signed [15:0] nx;
  logic signed [15:0] ny;
  logic signed [15:0] nz;
  logic               last;
} normal_t;

class normal_board;
  localparam int MAX_SIDE = 62;
  localparam int DEPTH    = 2 * MAX_SIDE + 2;
  localparam longint unsigned TINY_SQ = 64'd2882303761;

  longint  ring [DEPTH][3];
  int unsigned side_reg, col, row, emit;
  normal_t want_q [$];
  int      errors;

  function new();
    side_reg = 32;
    col = 0; row = 0; emit = 0; errors = 0;
  endfunction

  function void set_side(int unsigned s);
    side_reg = s; col = 0; row = 0; emit = 0;
  endfunction

  function longint unsigned mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function void unit14(input vec3_t v, output vec3_t o);
    longint unsigned m [3];
    longint unsigned mx, sum, len;
    longint q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + len / 2) / len;
      o[i] = (v[i] < 0) ? -q : q;
    end
  endfunction

  function void diff_unit(int unsigned e, int unsigned k, output vec3_t o);
    vec3_t d;
    for (int i = 0; i < 3; i++) d[i] = ring[e % DEPTH][i] - ring[k % DEPTH][i];
    unit14(d, o);
  endfunction

  function void cross3(input vec3_t a, input vec3_t b, output vec3_t o);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function void normal_at(int unsigned e, int unsigned side, output vec3_t n);
    int unsigned x, y;
    vec3_t up, rt, dn, lf, a, b, s, u;
    longint unsigned sq;
    longint q;
    x = e % side;
    y = e / side;
    sq = 0;
    if (x == 0 || y == 0 || x + 1 >= side || y + 1 >= side) begin
      n[0] = 0; n[1] = 0; n[2] = 16384;
      return;
    end
    diff_unit(e, e + side, up);
    diff_unit(e, e + 1, rt);
    diff_unit(e, e - side, dn);
    diff_unit(e, e - 1, lf);
    cross3(up, rt, a);
    cross3(dn, lf, b);
    for (int i = 0; i < 3; i++) begin
      s[i] = a[i] + b[i];
      sq += mag(s[i]) * mag(s[i]);
    end
    if (sq <= TINY_SQ) begin
      // near-flat sum stays unnormalized, scaled down to q1.14
      for (int i = 0; i < 3; i++) begin
        q = (mag(s[i]) + 16384) >> 15;
        u[i] = (s[i] < 0) ? -q : q;
      end
    end else begin
      unit14(s, u);
    end
    for (int i = 0; i < 3; i++) n[i] = -u[i];
  endfunction

  function void note_vertex(logic signed [23:0] px, logic signed [23:0] py,
                            logic signed [23:0] pz);
    int unsigned side, p, total;
    bit last;
    vec3_t n;
    normal_t w;
    side = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
    total = side * side;
    p = row * side + col;
    ring[p % DEPTH][0] = px;
    ring[p % DEPTH][1] = py;
    ring[p % DEPTH][2] = pz;
    last = (p + 1 == total);
    while (emit <= p && (emit + side + 1 <= p || last)) begin
      normal_at(emit, side, n);
      w.nx = n[0][15:0];
      w.ny = n[1][15:0];
      w.nz = n[2][15:0];
      w.last = last && (emit + 1 == total);
      want_q.push_back(w);
      emit++;
    end
    if (last) begin
      col = 0; row = 0; emit = 0;
    end else if (col + 1 >= side) begin
      col = 0; row++;
    end else begin
      col++;
    end
  endfunction

  function void check_normal(normal_t got);
    normal_t w;
    if (want_q.size() == 0) begin
      $display("%0t unexpected normal %0d %0d %0d last %0d", $time,
               got.nx, got.ny, got.nz, got.last);
      errors++;
      return;
    end
    w = want_q.pop_front();
    if (got.nx !== w.nx) begin
      $display("%0t normal_x exp %0d got %0d", $time, w.nx, got.nx);
      errors++;
    end
    if (got.ny !== w.ny) begin
      $display("%0t normal_y exp %0d got %0d", $time, w.ny, got.ny);
      errors++;
    end
    if (got.nz !== w.nz) begin
      $display("%0t normal_z exp %0d got %0d", $time, w.nz, got.nz);
      errors++;
    end
    if (got.last !== w.last) begin
      $display("%0t last_normal exp %0d got %0d", $time, w.last, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;
  import gsng_pkg::*;

  localparam int  CW    = 24;
  localparam int  LIMIT = 1000000;
  localparam logic signed [CW-1:0] CMIN = 24'sh800000;
  localparam logic signed [CW-1:0] CMAX = 24'sh7fffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [SIDE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NQ_W-1:0] normal_x, normal_y, normal_z;
  logic last_normal;

  normal_board board;
  int  sent = 0;
  bit  calm = 1'b0;
  int  cycles = 0;

  always #5 clk_i = ~clk_i;

  grid_surface_normal_generator_core #(.MAX_SIDE(62), .COORD_BITS(CW)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .normal_x_o(normal_x), .normal_y_o(normal_y), .normal_z_o(normal_z),
    .last_normal_o(last_normal)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls about a fifth of the time except in the calm stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready)
        board.check_normal('{normal_x, normal_y, normal_z, last_normal});
      out_ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z);
    int gap;
    gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    board.note_vertex(x, y, z);
    sent++;
  endtask

  // hold input until every owed normal word is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.want_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_side(logic [SIDE_W-1:0] s);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_side(s);
    @(posedge clk_i);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_vertex(CW'($urandom()), CW'($urandom()), CW'($urandom()));
  endtask

  // heightfield-like grid with random spacing, noise and height
  task automatic send_terrain(int side);
    int sx, sy, hz;
    sx = $urandom_range(2048, 16);
    sy = $urandom_range(2048, 16);
    hz = $urandom_range(20, 4);
    for (int r = 0; r < side; r++) begin
      for (int c = 0; c < side; c++) begin
        if ($urandom_range(99) < 5)
          send_vertex(CW'($urandom()), CW'($urandom()), CW'($urandom()));
        else
          send_vertex(CW'(c * sx + $signed($urandom_range(31)) - 16),
                      CW'(r * sy + $signed($urandom_range(31)) - 16),
                      CW'($signed($urandom() >> (32 - hz)) - (1 <<< (hz - 1))));
      end
    end
  endtask

  initial begin
    int pick;
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // side zero acts as one: every vertex is a whole grid
    write_side(SIDE_W'(0));
    send_vertex(CMIN, CMAX, CMIN);
    send_vertex(CMAX, CMIN, CMAX);
    // side two: all border
    write_side(SIDE_W'(2));
    send_random(4);
    // side three with extreme coordinates around the center
    write_side(SIDE_W'(3));
    for (int i = 0; i < 9; i++)
      send_vertex((i % 3 == 0) ? CMIN : ((i % 3 == 1) ? 24'sd0 : CMAX),
                  (i / 3 == 0) ? CMIN : ((i / 3 == 1) ? 24'sd0 : CMAX),
                  i[0] ? CMAX : CMIN);
    // flat grid of one repeated point: zero differences, zero sum
    for (int i = 0; i < 9; i++) send_vertex(24'sd1000, -24'sd77, 24'sd5);

    // largest side, partial grid, then an oversize value that clamps
    write_side(SIDE_W'(62));
    send_random(66);
    write_side(SIDE_W'(63));
    send_random(4);

    while (sent < 195) begin
      calm = (sent >= 120 && sent < 170);
      pick = $urandom_range(99);
      if (pick < 75) begin
        write_side(SIDE_W'($urandom_range(7, 3)));
        send_terrain(board.side_reg);
      end else if (pick < 90) begin
        write_side(SIDE_W'($urandom_range(8, 3)));
        send_random($urandom_range(board.side_reg * board.side_reg, 1));
      end else begin
        write_side(SIDE_W'($urandom_range(2, 1)));
        send_random(board.side_reg * board.side_reg);
      end
    end
    calm = 1'b0;

    drain();
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- grid_surface_normal_generator_core.f -----
design/gsng_pkg.sv
design/gsng_ram.sv
design/gsng_norm.sv
design/grid_surface_normal_generator_core.sv
tb/testbench.sv
